FILE: rtl/prh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// prh_pkg: shared types and constants of the polynomial rolling hash
// modulus, barrett constant, power table and the job record passed from the
// front end through the queue to the back end
// ---------------------------------------------------------------------------
package prh_pkg;

  localparam int unsigned HASH_W = 30;
  localparam int unsigned MAG_W  = 8;

  typedef logic [HASH_W-1:0] res_t;

  // prime modulus 10^9 + 9
  localparam res_t HASH_MOD = 30'd1000000009;
  // 2^64 mod HASH_MOD, added back when the 64-bit total wraps below zero
  localparam res_t WRAP_RES = 30'd688856453;
  // byte value that gives digit zero ('a' - 1)
  localparam logic [MAG_W-1:0] DIGIT_ZERO = 8'd96;

  // barrett reduction for values below 2^60: mu = floor(2^60 / m)
  localparam logic [60:0] MU_FULL    = (61'd1 << 60) / {31'd0, HASH_MOD};
  localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

  // latency of the modular multiplier, also the lag of the power ring
  localparam int unsigned MUL_LAT = 4;
  localparam int unsigned TAB_AW  = 2;
  localparam int unsigned LAG_W   = 3;

  // 257^i mod m for the first bytes of a string, before the ring is primed
  localparam res_t POW_TAB [MUL_LAT] = '{30'd1, 30'd257, 30'd66049, 30'd16974593};
  // 257^4 mod m, one trip around the ring
  localparam res_t RING_MUL = 30'd362470365;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // one classified byte
  typedef struct packed {
    res_t             power;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             last;
  } job_t;

  // control tag that rides along the back-end pipeline
  typedef struct packed {
    logic valid;
    logic neg;
    logic last;
  } tag_t;

endpackage
`default_nettype wire

FILE: rtl/prh_modmul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// prh_modmul: pipelined modular multiplier
// four stages: product, barrett estimate, remainder, final correction
// ---------------------------------------------------------------------------
module prh_modmul import prh_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  res_t              a,
  input  res_t              b,
  input  logic [SIDE_W-1:0] side_in,
  output res_t              res,
  output logic [SIDE_W-1:0] side_out,
  output logic              over
);

  logic [59:0]       prod1;
  logic [30:0]       quo2;
  logic [31:0]       low2;
  logic              over2;
  logic [31:0]       rem3;
  logic              over3;
  logic [SIDE_W-1:0] side1, side2, side3;

  logic [61:0] est;
  logic [60:0] qm_prod;
  logic [31:0] rem_next;
  logic [31:0] sub1, sub2;
  res_t        res_next;

  // quotient estimate, at most two short
  assign est     = {31'd0, prod1[59:29]} * {31'd0, BARRETT_MU};
  assign qm_prod = {30'd0, quo2} * {31'd0, HASH_MOD};
  assign rem_next = low2 - qm_prod[31:0];

  assign sub1 = rem3 - {2'b00, HASH_MOD};
  assign sub2 = rem3 - {1'b0, HASH_MOD, 1'b0};

  always_comb begin
    if (rem3 >= {1'b0, HASH_MOD, 1'b0}) begin
      res_next = sub2[HASH_W-1:0];
    end else if (rem3 >= {2'b00, HASH_MOD}) begin
      res_next = sub1[HASH_W-1:0];
    end else begin
      res_next = rem3[HASH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side1    <= '0;
      side2    <= '0;
      side3    <= '0;
      side_out <= '0;
    end else if (en) begin
      side1    <= side_in;
      side2    <= side1;
      side3    <= side2;
      side_out <= side3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= {30'd0, a} * {30'd0, b};
      quo2  <= est[61:31];
      low2  <= prod1[31:0];
      over2 <= (prod1 >= {30'd0, HASH_MOD});
      rem3  <= rem_next;
      over3 <= over2;
      res   <= res_next;
      over  <= over3;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/prh_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// prh_front: byte intake
// forms the digit sign and magnitude and the power of 257 for each byte
// ---------------------------------------------------------------------------
module prh_front import prh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       q_full,
  output logic       push,
  output job_t       job
);

  logic [LAG_W-1:0] lag;
  logic [LAG_W-1:0] lag_next;
  logic             primed;
  res_t             power;
  res_t             ring_res;
  logic             neg;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  // first bytes of a string take the table, later ones the ring output
  assign primed = (lag >= LAG_W'(MUL_LAT));
  assign power  = primed ? ring_res : POW_TAB[lag[TAB_AW-1:0]];

  assign neg = (s_tdata < DIGIT_ZERO);

  always_comb begin
    job.power = power;
    job.neg   = neg;
    job.last  = s_tlast;
    job.mag   = neg ? (DIGIT_ZERO - s_tdata) : (s_tdata - DIGIT_ZERO);
  end

  // each lap multiplies by 257^4, so the output is the power four bytes on
  prh_modmul #(.SIDE_W(1)) u_ring (
    .clk      (clk),
    .rst      (rst),
    .en       (push),
    .a        (power),
    .b        (RING_MUL),
    .side_in  (1'b0),
    .res      (ring_res),
    .side_out (),
    .over     ()
  );

  always_comb begin
    lag_next = lag;
    priority if (push && s_tlast) begin
      lag_next = '0;
    end else if (push && !primed) begin
      lag_next = lag + 1'b1;
    end else begin
      lag_next = lag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag <= '0;
    end else begin
      lag <= lag_next;
    end
  end

  a_lag_range: assert property (@(posedge clk) disable iff (rst)
    lag <= LAG_W'(MUL_LAT))
    else $error("string position counter past ring lag");

  a_power_ok: assert property (@(posedge clk) disable iff (rst)
    push |-> (power != '0) && (power < HASH_MOD))
    else $error("power of 257 out of range");

endmodule
`default_nettype wire

FILE: rtl/prh_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// prh_queue: small register queue of classified bytes
// decouples the intake from the arithmetic back end
// ---------------------------------------------------------------------------
module prh_queue import prh_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic valid
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (push) begin
      wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
  end

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: rtl/prh_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// prh_back: arithmetic back end
// digit times power mod m, wrap correction, running sum and result register
// ---------------------------------------------------------------------------
module prh_back import prh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  job_t q_job,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t hash
);

  localparam int unsigned TAG_W = $bits(tag_t);

  logic en;
  tag_t tag_in, tag4, tag5;
  res_t qm4;
  logic over4;

  // stage 5 values
  res_t qr5, qk5, qm5;
  logic over5;

  // combinational
  res_t        qr;
  logic [30:0] qk_sum, qk_sub;
  res_t        qk;
  logic        wrap;
  logic [30:0] acc_sum, acc_sub;
  res_t        sum_next;
  res_t        sum;

  // the whole back end moves together, held only by a full result register
  assign en  = !out_valid || out_ready;
  assign pop = en && q_valid;

  always_comb begin
    tag_in.valid = q_valid;
    tag_in.neg   = q_job.neg;
    tag_in.last  = q_job.last;
  end

  prh_modmul #(.SIDE_W(TAG_W)) u_mul (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .a        (q_job.power),
    .b        ({{(HASH_W - MAG_W){1'b0}}, q_job.mag}),
    .side_in  (tag_in),
    .res      (qm4),
    .side_out (tag4),
    .over     (over4)
  );

  // signed term mod m, and the same plus 2^64 mod m
  always_comb begin
    if (tag4.neg && (qm4 != '0)) begin
      qr = HASH_MOD - qm4;
    end else begin
      qr = qm4;
    end
    qk_sum = {1'b0, qr} + {1'b0, WRAP_RES};
    qk_sub = qk_sum - {1'b0, HASH_MOD};
    qk     = (qk_sum >= {1'b0, HASH_MOD}) ? qk_sub[HASH_W-1:0] : qk_sum[HASH_W-1:0];
  end

  // running sum loop: the 64-bit total wraps when the magnitude beats the sum
  always_comb begin
    wrap     = tag5.neg && (over5 || (sum < qm5));
    acc_sum  = {1'b0, sum} + {1'b0, (wrap ? qk5 : qr5)};
    acc_sub  = acc_sum - {1'b0, HASH_MOD};
    sum_next = (acc_sum >= {1'b0, HASH_MOD}) ? acc_sub[HASH_W-1:0] : acc_sum[HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag5      <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      tag5      <= tag4;
      out_valid <= tag5.valid && tag5.last;
      if (tag5.valid) begin
        sum <= tag5.last ? '0 : sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qr5   <= qr;
      qk5   <= qk;
      qm5   <= qm4;
      over5 <= over4;
      if (tag5.valid && tag5.last) begin
        hash <= sum_next;
      end
    end
  end

  a_sum_reduced: assert property (@(posedge clk) disable iff (rst)
    sum < HASH_MOD)
    else $error("running sum not reduced");

  a_hash_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hash < HASH_MOD)
    else $error("hash not reduced");

endmodule
`default_nettype wire

FILE: rtl/polynomial_rolling_hash_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// polynomial_rolling_hash_unit: base 257 string hash modulo 10^9 + 9
// streams bytes in, one hash out per string
// ---------------------------------------------------------------------------
// Bytes of a string arrive one item at a time on the slave stream, with tlast
// on the final byte; each string gives one hash on the master stream. Each
// byte b contributes the digit (b - 96) times 257^i, where i is its position
// in the string; digits of bytes below 96 are negative and enter the sum as
// 64-bit two's complement words, so a sum that dips below zero picks up
// 2^64 mod m before the reduction. The unit takes one byte per clock while
// the queue has room and keeps that rate across string boundaries. The rate
// is set by the running-sum update, a combinational add, compare and subtract;
// the powers of 257 come from a four-stage Barrett multiplier closed into a
// ring that multiplies by 257^4, seeded from a small table for the first four
// bytes of each string. Bytes pass through a short queue into the back end;
// while a finished hash waits in the output register the back end holds, and
// the input still takes up to QUEUE_DEPTH bytes before tready drops.
// A hash passes the queue, the four multiplier stages, stage 5 and the result register.
// QUEUE_DEPTH sets the queue size and must be at least two.
// ---------------------------------------------------------------------------
module polynomial_rolling_hash_unit import prh_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // final_byte
  // hash stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [29:0] hash_value, [31:30] zero
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic pop;
  res_t hash;

  // intake: digit and power per byte
  prh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  // decoupling queue between intake and arithmetic
  prh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_job),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_job),
    .valid (q_valid)
  );

  // product, reduction, running sum, result register
  prh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .hash      (hash)
  );

  assign m_tdata = {{(32 - HASH_W){1'b0}}, hash};

endmodule
`default_nettype wire

FILE: tb/hash_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hash_checker: scoreboard for the polynomial rolling hash unit
// watches both streams, folds every accepted byte into its own running sum
// and power, queues one hash per string and compares each returned hash
// ---------------------------------------------------------------------------
module hash_checker import prh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // final_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [29:0] hash_value, [31:30] zero
  output int          errors,
  output int          outstanding,
  output int          hashes_seen
);

  localparam logic [63:0] BASE = 64'd257;

  res_t acc_sum;
  res_t acc_power;
  res_t hash_expected[$];
  res_t want;
  int   err_count = 0;
  int   hash_count = 0;

  // new running sum; the digit wraps as a 64-bit word, as does the total
  function automatic res_t fold_byte(res_t sum, res_t power, logic [7:0] b);
    logic [63:0] digit;
    logic [63:0] total;
    digit = {56'd0, b} - {56'd0, DIGIT_ZERO};
    total = {34'd0, sum} + digit * {34'd0, power};
    return res_t'(total % {34'd0, HASH_MOD});
  endfunction

  function automatic res_t step_power(res_t power);
    logic [63:0] prod;
    prod = {34'd0, power} * BASE;
    return res_t'(prod % {34'd0, HASH_MOD});
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc_sum = '0;
      acc_power = res_t'(1);
      hash_expected.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        acc_sum = fold_byte(acc_sum, acc_power, s_tdata);
        acc_power = step_power(acc_power);
        if (s_tlast) begin
          hash_expected.push_back(acc_sum);
          acc_sum = '0;
          acc_power = res_t'(1);
        end
      end
      if (m_tvalid && m_tready) begin
        hash_count++;
        if (hash_expected.size() == 0) begin
          report_mismatch($sformatf("hash %0d with no string pending", m_tdata[29:0]));
        end else begin
          want = hash_expected.pop_front();
          if (m_tdata[29:0] !== want)
            report_mismatch($sformatf("hash_value %0d, expected %0d", m_tdata[29:0], want));
          if (m_tdata[31:30] !== 2'b00)
            report_mismatch($sformatf("pad bits of tdata are %b", m_tdata[31:30]));
        end
      end
    end
    errors      <= err_count;
    outstanding <= hash_expected.size();
    hashes_seen <= hash_count;
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for polynomial_rolling_hash_unit
// sends directed and random strings with random gaps while the output side
// stalls at random, including one long hold-off that backs up the input;
// the hash_checker beside the unit predicts and compares every hash
// ---------------------------------------------------------------------------
module tb_top;

  localparam int BYTE_TARGET = 1450;
  localparam int HOLD_START  = 600;   // cycles of traffic before the long hold-off
  localparam int HOLD_CYCLES = 250;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;    // margin for the last hash to leave the pipeline

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;     // [7:0] byte_value
  logic        s_tlast = 1'b0;     // final_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;            // [29:0] hash_value, [31:30] zero

  int errors;
  int outstanding;
  int hashes_seen;

  logic [7:0] text[$];
  logic       burst = 1'b0;       // no gaps inside the current string
  int         bytes_sent = 0;
  int         strings_sent = 0;
  int         longest = 0;

  polynomial_rolling_hash_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  hash_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .errors      (errors),
    .outstanding (outstanding),
    .hashes_seen (hashes_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout: %0d bytes sent, %0d hashes pending", bytes_sent, outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_edge_byte();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h5F;   // smallest negative digit magnitude
      3: return 8'h60;   // digit zero
      default: return 8'h61;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++)
      send_byte(text[i], i == text.size() - 1);
    strings_sent++;
    if (text.size() > longest) longest = text.size();
  endtask

  // output side: mostly ready, with one long hold-off so the unit fills up
  initial begin
    int run;
    int cycles;
    bit held;
    cycles = 0;
    held = 0;
    wait (!rst);
    forever begin
      if (!held && cycles >= HOLD_START) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1;
      end else if ($urandom_range(0, 3) != 0) begin
        m_tready <= 1'b1;
        run = $urandom_range(1, 20);
        repeat (run) @(posedge clk);
        cycles += run;
      end else begin
        m_tready <= 1'b0;
        run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (run) @(posedge clk);
        cycles += run;
      end
    end
  end

  initial begin
    int len;
    int flavor;
    int waited;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // single bytes at the digit extremes, digit zero and 'a'
    text = '{8'h00}; send_text();
    text = '{8'hFF}; send_text();
    text = '{8'h60}; send_text();
    text = '{8'h61}; send_text();
    // all-negative digits drive the 64-bit total below zero; all-0xFF gives maximum digits
    burst = 1'b1;
    text = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}; send_text();
    text = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}; send_text();
    burst = 1'b0;
    text = '{8'h61, 8'h62, 8'h63}; send_text();
    // boundary around digit zero
    text = '{8'h5F, 8'h60}; send_text();

    // random strings, mostly short lower-case words
    while (bytes_sent < BYTE_TARGET) begin
      len = $urandom_range(0, 99);
      if (len < 85)      len = $urandom_range(1, 8);
      else if (len < 97) len = $urandom_range(9, 40);
      else               len = $urandom_range(41, 120);
      flavor = $urandom_range(0, 9);
      burst = ($urandom_range(0, 9) < 3);
      text.delete();
      for (int i = 0; i < len; i++) begin
        if (flavor < 6)      text.push_back(8'($urandom_range(97, 122)));
        else if (flavor < 8) text.push_back(8'($urandom_range(0, 255)));
        else if ($urandom_range(0, 1) == 0) text.push_back(pick_edge_byte());
        else                 text.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
    end
    s_tvalid <= 1'b0;

    // let the last hashes drain
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d strings, longest %0d bytes, output held off %0d cycles",
             bytes_sent, strings_sent, longest, HOLD_CYCLES);
    $display("received %0d hashes, %0d never arrived", hashes_seen, outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
